// ===== sv/ipv4_range_text_parser_top_macros.svh =====
// Assertion macros used by the RTL top module.
`ifndef IPV4_RANGE_TEXT_PARSER_TOP_MACROS_SVH
`define IPV4_RANGE_TEXT_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ipv4rp_pkg.sv =====
package ipv4rp_pkg;

  // address form
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_PREFIX = 2'd1;
  localparam logic [1:0] MODE_RANGE  = 2'd2;

  // status codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_OVER    = 3'd1;
  localparam logic [2:0] ERR_FEW     = 3'd2;
  localparam logic [2:0] ERR_MANY    = 3'd3;
  localparam logic [2:0] ERR_PREFIX  = 3'd4;
  localparam logic [2:0] ERR_MALFORM = 3'd5;

  // characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [8:0] PART_SAT   = 9'd256;
  localparam logic [5:0] PREFIX_SAT = 6'd33;
  localparam logic [5:0] PREFIX_MAX = 6'd32;
  localparam logic [2:0] PARTS_FULL = 3'd4;

  // beat widths, padded to whole bytes
  localparam int unsigned IN_W  = 8;
  localparam int unsigned OUT_W = 72;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  value;
    logic        has_digit;
    logic [2:0]  count;
    logic [31:0] acc;
    logic [31:0] saved;
    logic [5:0]  prefix;
    logic [2:0]  err;
  } parse_state_t;

  // every field resets to zero: plain form, no error
  localparam parse_state_t PARSE_RESET = '0;

  // End of one dotted component: shift it into the accumulator.
  function automatic parse_state_t close_part(parse_state_t s);
    parse_state_t r;
    r = s;
    if (!s.has_digit) begin
      if (r.err == ERR_NONE) r.err = ERR_MALFORM;
    end else if (s.value > 9'd255) begin
      if (r.err == ERR_NONE) r.err = ERR_OVER;
    end else begin
      r.acc       = {s.acc[23:0], s.value[7:0]};
      r.count     = s.count + 3'd1;
      r.value     = '0;
      r.has_digit = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/ipv4_range_text_parser_top.sv =====
// IPv4 range text parser. Characters of a range text ("a.b.c.d", "a.b.c.d/n"
// or "a.b.c.d-x.y") arrive one per slave beat, the final one marked by tlast;
// one master beat follows each text with first and last address and a status
// (0 ok, 1 component over 255, 2 too few components, 3 too many, 4 prefix
// over 32, 5 malformed; addresses are zero unless ok). One character is taken
// every cycle while no last character is stalled: the parse state updates once
// per character, and that per-character update loop sets the rate. A character
// is held in the input register, and the result beat is registered when its
// last character leaves that register. A pending result that the sink has not
// taken stalls only a following last character; ordinary characters keep
// flowing.
`include "ipv4_range_text_parser_top_macros.svh"

module ipv4_range_text_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ipv4rp_pkg::IN_W-1:0]   s_tdata,   // [7:0] text_char
  input  logic                          s_tlast,   // is_last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ipv4rp_pkg::OUT_W-1:0]  m_tdata    // [31:0] first_address,
                                                   // [63:32] last_address,
                                                   // [66:64] status, rest 0
);
  import ipv4rp_pkg::*;

  // input register
  logic        in_valid;
  logic [7:0]  in_char;
  logic        in_last;

  // parse state
  parse_state_t st, st_next, st_step;

  // result register
  logic [31:0] first_address, last_address;
  logic [2:0]  status;

  logic [31:0] res_first, res_last;
  logic [2:0]  res_status;
  logic        fire;

  // a last character needs a free result slot; others never wait
  assign fire     = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_comb begin
    parse_state_t v;
    logic [11:0]  tv;
    logic [8:0]   tp;
    logic [3:0]   d;
    logic [31:0]  mask;
    logic [31:0]  tmp;
    logic [31:0]  fa, la;
    v    = st;
    d    = in_char[3:0];
    tv   = {3'b0, st.value} * 12'd10 + {8'b0, d};
    tp   = {3'b0, st.prefix} * 9'd10 + {5'b0, d};
    mask = '0;
    tmp  = '0;
    fa   = '0;
    la   = '0;

    if (v.err == ERR_NONE) begin
      if (in_char inside {[CH_ZERO:CH_NINE]}) begin
        v.has_digit = 1'b1;
        if (v.mode == MODE_PREFIX) begin
          v.prefix = (tp > {3'b0, PREFIX_SAT}) ? PREFIX_SAT : tp[5:0];
        end else begin
          v.value = (tv > {3'b0, PART_SAT}) ? PART_SAT : tv[8:0];
        end
      end else if (in_char == CH_DOT && v.mode != MODE_PREFIX) begin
        v = close_part(v);
        if (v.err == ERR_NONE && v.count >= PARTS_FULL) v.err = ERR_MANY;
      end else if ((in_char == CH_DASH || in_char == CH_SLASH) && v.mode == MODE_PLAIN) begin
        v = close_part(v);
        if (v.err == ERR_NONE && v.count < PARTS_FULL) v.err = ERR_FEW;
        if (v.err == ERR_NONE) begin
          if (in_char == CH_SLASH) begin
            v.mode      = MODE_PREFIX;
            v.has_digit = 1'b0;
          end else begin
            v.mode  = MODE_RANGE;
            v.saved = v.acc;
            v.acc   = '0;
            v.count = '0;
          end
        end
      end else begin
        v.err = ERR_MALFORM;
      end
    end

    // wrap-up on the final character
    if (in_last && v.err == ERR_NONE) begin
      if (v.mode == MODE_PREFIX) begin
        if (!v.has_digit) begin
          v.err = ERR_MALFORM;
        end else if (v.prefix > PREFIX_MAX) begin
          v.err = ERR_PREFIX;
        end else begin
          // zero prefix gives an all-zero mask, 32 an all-ones mask
          mask = ~(32'hFFFF_FFFF >> v.prefix);
          fa   = v.acc & mask;
          la   = v.acc | ~mask;
        end
      end else begin
        v = close_part(v);
        if (v.err == ERR_NONE) begin
          if (v.mode == MODE_PLAIN) begin
            if (v.count < PARTS_FULL) begin
              v.err = ERR_FEW;
            end else begin
              fa = v.acc;
              la = v.acc;
            end
          end else begin
            // short second address borrows high bytes of the first
            mask = (v.count >= PARTS_FULL) ? 32'h0
                 : (32'hFFFF_FFFF << {v.count, 3'b000});
            fa = v.saved;
            la = (v.saved & mask) | v.acc;
            if (fa > la) begin
              tmp = fa;
              fa  = la;
              la  = tmp;
            end
          end
        end
      end
    end

    if (v.err != ERR_NONE) begin
      fa = '0;
      la = '0;
    end
    st_step    = v;
    res_first  = fa;
    res_last   = la;
    res_status = v.err;
  end

  always_comb begin
    st_next = st;
    if (fire) st_next = in_last ? PARSE_RESET : st_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      st       <= PARSE_RESET;
    end else begin
      st <= st_next;
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_char  <= s_tdata[7:0];
        in_last  <= s_tlast;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire && in_last) begin
        m_tvalid      <= 1'b1;
        first_address <= res_first;
        last_address  <= res_last;
        status        <= res_status;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {5'b0, status, last_address, first_address};

  // error beats carry zero addresses; good beats are ordered
  `ASSERT_IMPL(a_err_zero, m_tvalid && status != ERR_NONE,
               first_address == 32'h0 && last_address == 32'h0)
  `ASSERT_IMPL(a_ordered, m_tvalid && status == ERR_NONE, first_address <= last_address)
  `ASSERT_IMPL(a_status_code, m_tvalid, status <= ERR_MALFORM)
  // a finished text produces a beat and leaves a clean parse state
  `ASSERT_NEXT(a_last_beat, fire && in_last, m_tvalid)
  `ASSERT_NEXT(a_last_clear, fire && in_last,
               st.mode == MODE_PLAIN && st.err == ERR_NONE && st.count == 3'd0)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ipv4rp_pkg::*;

  localparam int unsigned RANDOM_CHARS = 2000;
  localparam int unsigned HOLD_LEN     = 300;     // long receiver hold-off, cycles
  localparam int unsigned TAIL_CYCLES  = 8;       // idle cycles at the end of the run
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // one expected result beat
  typedef struct packed {
    logic [31:0] lo_addr;
    logic [31:0] hi_addr;
    logic [2:0]  status;
  } range_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  ipv4_range_text_parser_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser state mirror. Updated once per accepted character beat.
  // ---------------------------------------------------------------------------
  logic [1:0]  form_state;
  logic [8:0]  octet_val;      // saturates at 256
  logic        has_digits;
  logic [2:0]  octets_done;
  logic [31:0] addr_acc;
  logic [31:0] range_start;
  logic [5:0]  prefix_val;     // saturates at 33
  logic [2:0]  first_err;

  range_result_t pending_ranges[$];   // results still owed by the block

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned chars_sent = 0;
  logic [7:0]  text_q[$];             // text being built / sent

  bit tx_idles = 1'b1;
  bit rx_idles = 1'b1;
  int unsigned hold_req = 0;          // bumped by a test to start a hold-off
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  function automatic void clear_parser();
    form_state  = MODE_PLAIN;
    octet_val   = '0;
    has_digits  = 1'b0;
    octets_done = '0;
    addr_acc    = '0;
    range_start = '0;
    prefix_val  = '0;
    first_err   = ERR_NONE;
  endfunction

  // only the first error of a text sticks
  function automatic void raise_status(input logic [2:0] code);
    if (first_err == ERR_NONE) first_err = code;
  endfunction

  function automatic void shift_octet();
    if (!has_digits) begin
      raise_status(ERR_MALFORM);
    end else if (octet_val > 9'd255) begin
      raise_status(ERR_OVER);
    end else begin
      addr_acc    = {addr_acc[23:0], octet_val[7:0]};
      octets_done = octets_done + 3'd1;
      octet_val   = '0;
      has_digits  = 1'b0;
    end
  endfunction

  function automatic void parse_char(input logic [7:0] ch, input logic is_end);
    int unsigned   t;
    logic [31:0]   mask;
    logic [31:0]   lo;
    logic [31:0]   hi;
    logic [31:0]   swap;
    range_result_t res;
    lo = '0;
    hi = '0;
    if (first_err == ERR_NONE) begin
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        has_digits = 1'b1;
        if (form_state == MODE_PREFIX) begin
          t = 32'(prefix_val) * 10 + 32'(ch - CH_ZERO);
          prefix_val = (t > 33) ? PREFIX_SAT : t[5:0];
        end else begin
          t = 32'(octet_val) * 10 + 32'(ch - CH_ZERO);
          octet_val = (t > 256) ? PART_SAT : t[8:0];
        end
      end else if (ch == CH_DOT && form_state != MODE_PREFIX) begin
        shift_octet();
        if (first_err == ERR_NONE && octets_done >= PARTS_FULL) raise_status(ERR_MANY);
      end else if ((ch == CH_DASH || ch == CH_SLASH) && form_state == MODE_PLAIN) begin
        shift_octet();
        if (first_err == ERR_NONE && octets_done < PARTS_FULL) raise_status(ERR_FEW);
        if (first_err == ERR_NONE) begin
          if (ch == CH_SLASH) begin
            form_state = MODE_PREFIX;
            has_digits = 1'b0;
          end else begin
            form_state  = MODE_RANGE;
            range_start = addr_acc;
            addr_acc    = '0;
            octets_done = '0;
          end
        end
      end else begin
        raise_status(ERR_MALFORM);
      end
    end

    if (!is_end) return;

    if (first_err == ERR_NONE) begin
      if (form_state == MODE_PREFIX) begin
        if (!has_digits) begin
          raise_status(ERR_MALFORM);
        end else if (prefix_val > PREFIX_MAX) begin
          raise_status(ERR_PREFIX);
        end else begin
          mask = (prefix_val == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - prefix_val));
          lo = addr_acc & mask;
          hi = addr_acc | ~mask;
        end
      end else begin
        shift_octet();
        if (first_err == ERR_NONE) begin
          if (form_state == MODE_PLAIN) begin
            if (octets_done < PARTS_FULL) begin
              raise_status(ERR_FEW);
            end else begin
              lo = addr_acc;
              hi = addr_acc;
            end
          end else begin
            // short second address borrows its high bytes from the first
            mask = (octets_done >= PARTS_FULL) ? 32'h0 :
                   (32'hFFFF_FFFF << (8 * octets_done));
            lo = range_start;
            hi = (range_start & mask) | addr_acc;
            if (lo > hi) begin
              swap = lo;
              lo   = hi;
              hi   = swap;
            end
          end
        end
      end
    end

    if (first_err != ERR_NONE) begin
      lo = '0;
      hi = '0;
    end
    res.lo_addr = lo;
    res.hi_addr = hi;
    res.status  = first_err;
    pending_ranges.push_back(res);
    clear_parser();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Called right after a rising edge; returns right after the
  // edge that took the beat, with tvalid still high.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input logic is_end);
    if (tx_idles && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= is_end;
    do @(posedge clk); while (!s_tready);
    parse_char(ch, is_end);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // sender stops until every owed result has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_ranges.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Random text builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_symbol();
    string syms;
    syms = "0123456789.-/";
    return syms[$urandom_range(syms.len() - 1)];
  endfunction

  task automatic add_num(input int unsigned v);
    string s;
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO);   // leading zeros
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_octet();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10)      add_num(0);
    else if (r < 20) add_num(255);
    else if (r < 88) add_num($urandom_range(255));
    else if (r < 96) add_num($urandom_range(256, 999));
    else             add_num($urandom);         // long digit string, saturates
  endtask

  task automatic add_address(input int unsigned parts);
    for (int i = 0; i < parts; i++) begin
      if (i != 0) text_q.push_back(CH_DOT);
      add_octet();
    end
  endtask

  // mostly well-formed texts with random content; some noise and damage
  task automatic build_text();
    int unsigned r;
    int unsigned n;
    text_q.delete();
    r = $urandom_range(99);
    if (r < 8) begin
      n = $urandom_range(1, 10);
      repeat (n) text_q.push_back($urandom_range(1) ? 8'($urandom_range(255)) : pick_symbol());
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : 4;
      add_address(n);
      r = $urandom_range(2);
      if (r == 1) begin
        text_q.push_back(CH_SLASH);
        r = $urandom_range(99);
        if (r < 8)       ;                                  // empty prefix
        else if (r < 85) add_num($urandom_range(32));
        else if (r < 95) add_num($urandom_range(33, 99));
        else             add_num($urandom);
      end else if (r == 2) begin
        text_q.push_back(CH_DASH);
        n = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : $urandom_range(1, 4);
        add_address(n);
      end
      if ($urandom_range(9) == 0 && text_q.size() != 0) begin
        n = $urandom_range(text_q.size() - 1);
        text_q[n] = $urandom_range(1) ? 8'($urandom_range(255)) : pick_symbol();
      end
    end
    if (text_q.size() == 0) text_q.push_back(CH_DOT);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_address_forms();
    send_string("0.0.0.0");
    send_string("255.255.255.255");
    send_string("10.1.2.3/8");
    send_string("1.2.3.4/0");               // whole space
    send_string("1.2.3.4/00000000032");
    send_string("1.2.3.4-5.6");             // short second address
    send_string("0.0.0.0-7");               // short second address on zero
    send_string("5.6.7.8-1.2.3.4");         // reversed range
    send_string("1.2.3.4-1.2.3.4");
    wait_for_results();
  endtask

  task automatic test_error_status();
    send_string("1.2.3.256");
    send_string("1.2.3.999999");            // digits saturate
    send_string("1.2.3");
    send_string("1.2.3/4");                 // short address before prefix
    send_string("1.2.3.4.5");               // dot after fourth component
    send_string("1.2.3.4-1.2.3.4.5");
    send_string("1.2.3.4/33");
    send_string("1.2.3.4/");                // empty prefix
    send_string("1..2.3");
    send_string(".1.2.3.4");
    send_string("1.2.3.4-");
    send_string("1.2.3.4/1.2");             // dot after slash
    send_string("1.2.3.4-5-6");
    send_string("1.2.3.4/5/6");
    text_q = '{8'h31, CH_DOT, 8'h32, 8'hFF, 8'h00};   // stray bytes, error then more
    send_text();
    wait_for_results();
  endtask

  // receiver stalls for a long stretch while texts keep coming
  task automatic test_receiver_hold();
    hold_req++;
    repeat (8) begin
      build_text();
      send_text();
    end
    wait_for_results();
  endtask

  task automatic test_random_texts();
    int unsigned start;
    int unsigned texts;
    start = chars_sent;
    texts = 0;
    while (chars_sent - start < RANDOM_CHARS) begin
      // a stretch with no idling on either side
      tx_idles = !(texts >= 40 && texts < 80);
      rx_idles = tx_idles;
      build_text();
      send_text();
      texts++;
    end
    tx_idles = 1'b1;
    rx_idles = 1'b1;
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus the requested hold-off, counted here
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(rx_idles && $urandom_range(99) < 7);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    range_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_ranges.size() == 0) begin
        report_mismatch("result beat with nothing owed", m_tdata[31:0], 32'h0);
      end else begin
        want = pending_ranges.pop_front();
        if (m_tdata[66:64] != want.status)
          report_mismatch("status", 32'(m_tdata[66:64]), 32'(want.status));
        if (m_tdata[31:0] != want.lo_addr)
          report_mismatch("first address", m_tdata[31:0], want.lo_addr);
        if (m_tdata[63:32] != want.hi_addr)
          report_mismatch("last address", m_tdata[63:32], want.hi_addr);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_address_forms();
    test_error_status();
    test_receiver_hold();
    test_random_texts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_ranges.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
